/* src/vdn_pkg.sv */
// Shared types and constants for the four-component vector dot and normalize unit.
package vdn_pkg;

  // Default component width and fixed result widths.
  localparam int DEF_COMP_WIDTH = 16;
  localparam int SCALAR_W       = 34;
  localparam int NORM_W         = 16;
  localparam int NORM_FRAC      = 14;
  localparam int NORM_ONE       = 16384;
  // Quotient bits resolved by the divider, one per stage.
  localparam int QUOT_W         = 15;
  // Divider depth: one setup stage plus one stage per quotient bit.
  localparam int DIV_LAT        = QUOT_W + 1;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_DOT  = 2'd0,
    FUNC_SQ   = 2'd1,
    FUNC_MAG  = 2'd2,
    FUNC_NORM = 2'd3
  } func_t;

  // Control and scalar result that travel alongside the datapath.
  typedef struct packed {
    logic                valid;
    func_t               func;
    logic                zero;
    logic [SCALAR_W-1:0] scalar;
  } ctl_t;

endpackage

/* src/vdn_mac.sv */
// Multiply stage and adder stage forming the dot product and squared magnitude.
module vdn_mac import vdn_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH,
  parameter int SQ_W       = 34
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  func_t                              in_func,
  input  logic signed [3:0][COMP_WIDTH-1:0]  in_a,
  input  logic signed [3:0][COMP_WIDTH-1:0]  in_b,
  output ctl_t                               ctl,
  output logic        [SQ_W-1:0]             sq,
  output logic signed [3:0][COMP_WIDTH-1:0]  a_out
);

  localparam int PW = 2 * COMP_WIDTH;
  localparam int SW = 2 * COMP_WIDTH + 2;

  // Stage one registers.
  logic                          v1;
  func_t                         func1;
  logic signed [3:0][PW-1:0]     pd;
  logic signed [3:0][PW-1:0]     ps;
  logic signed [3:0][COMP_WIDTH-1:0] a1;

  logic signed [SW-1:0] dsum;
  logic signed [SW-1:0] ssum;

  // Stage one: the eight products, two per component.
  // Elements of a packed array read as unsigned, so each is taken as signed here.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    func1 <= in_func;
    a1    <= in_a;
    for (int i = 0; i < 4; i++) begin
      pd[i] <= PW'($signed(in_a[i]) * $signed(in_b[i]));
      ps[i] <= PW'($signed(in_a[i]) * $signed(in_a[i]));
    end
  end

  // Sums of the sign-extended products, wide enough to never overflow.
  always_comb begin
    dsum = SW'($signed(pd[0])) + SW'($signed(pd[1])) + SW'($signed(pd[2])) +
           SW'($signed(pd[3]));
    ssum = SW'($signed(ps[0])) + SW'($signed(ps[1])) + SW'($signed(ps[2])) +
           SW'($signed(ps[3]));
  end

  // Stage two: scalar selection and the zero test.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= v1;
    end
    ctl.func   <= func1;
    ctl.zero   <= (a1 == '0);
    ctl.scalar <= (func1 == FUNC_DOT) ? SCALAR_W'(dsum) : SCALAR_W'(ssum);
    sq         <= SQ_W'(ssum);
    a_out      <= a1;
  end

endmodule

/* src/vdn_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
module vdn_sqrt import vdn_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH,
  parameter int SQ_W       = 34,
  parameter int MAG_W      = 17
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ctl_t                               ctl_in,
  input  logic        [SQ_W-1:0]             sq,
  input  logic signed [3:0][COMP_WIDTH-1:0]  a_in,
  output ctl_t                               ctl_out,
  output logic        [MAG_W-1:0]            mag,
  output logic signed [3:0][COMP_WIDTH-1:0]  a_out
);

  localparam int RW = 2 * MAG_W + 2;

  logic [RW-1:0]    rem  [0:MAG_W];
  logic [MAG_W-1:0] root [0:MAG_W];
  ctl_t             ctl  [0:MAG_W];
  logic signed [3:0][COMP_WIDTH-1:0] av [0:MAG_W];

  assign rem[0]  = RW'(sq);
  assign root[0] = '0;
  assign ctl[0]  = ctl_in;
  assign av[0]   = a_in;

  // Each stage tries one root bit: adding 2^k grows the square by
  // root*2^(k+1) + 2^(2k), which is taken from the remainder if it fits.
  for (genvar s = 0; s < MAG_W; s++) begin : g_stage
    localparam int K = MAG_W - 1 - s;
    logic [RW-1:0] test;

    always_comb begin
      test = (RW'(root[s]) << (K + 1)) + (RW'(1) << (2 * K));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].valid <= 1'b0;
      end else begin
        ctl[s+1].valid <= ctl[s].valid;
      end
      ctl[s+1].func   <= ctl[s].func;
      ctl[s+1].zero   <= ctl[s].zero;
      ctl[s+1].scalar <= ctl[s].scalar;
      av[s+1]         <= av[s];
      if (rem[s] >= test) begin
        rem[s+1]  <= rem[s] - test;
        root[s+1] <= root[s] | (MAG_W'(1) << K);
      end else begin
        rem[s+1]  <= rem[s];
        root[s+1] <= root[s];
      end
    end
  end

  assign ctl_out = ctl[MAG_W];
  assign mag     = root[MAG_W];
  assign a_out   = av[MAG_W];

endmodule

/* src/vdn_div.sv */
// Pipelined restoring divider for one component: |a| * 2^14 / magnitude.
module vdn_div import vdn_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH,
  parameter int MAG_W      = 17
) (
  input  logic                         clk,
  input  logic signed [COMP_WIDTH-1:0] a,
  input  logic        [MAG_W-1:0]      mag,
  output logic                         neg,
  output logic                         sat,
  output logic        [QUOT_W-1:0]     quot
);

  localparam int DW = MAG_W + COMP_WIDTH + QUOT_W + 2;

  logic [COMP_WIDTH-1:0] ua;
  logic [DW-1:0]         r   [0:QUOT_W];
  logic [MAG_W-1:0]      dv  [0:QUOT_W];
  logic [QUOT_W-1:0]     q   [0:QUOT_W];
  logic                  ng  [0:QUOT_W];
  logic                  st  [0:QUOT_W];

  assign ua = a[COMP_WIDTH-1] ? COMP_WIDTH'(-a) : COMP_WIDTH'(a);

  // Setup stage: magnitude of the numerator and the overflow test.
  // The quotient reaches 2^15 exactly when |a| >= 2 * magnitude.
  always_ff @(posedge clk) begin
    r[0]  <= DW'(ua) << NORM_FRAC;
    dv[0] <= mag;
    q[0]  <= '0;
    ng[0] <= a[COMP_WIDTH-1];
    st[0] <= (DW'(ua) >= (DW'(mag) << 1));
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int K = QUOT_W - 1 - s;
    logic [DW-1:0] sub;

    always_comb begin
      sub = DW'(dv[s]) << K;
    end

    always_ff @(posedge clk) begin
      dv[s+1] <= dv[s];
      ng[s+1] <= ng[s];
      st[s+1] <= st[s];
      if (r[s] >= sub) begin
        r[s+1] <= r[s] - sub;
        q[s+1] <= q[s] | (QUOT_W'(1) << K);
      end else begin
        r[s+1] <= r[s];
        q[s+1] <= q[s];
      end
    end
  end

  assign neg  = ng[QUOT_W];
  assign sat  = st[QUOT_W];
  assign quot = q[QUOT_W];

endmodule

/* src/vec4_dot_norm_unit_top.sv */
// A request flows through the multiply and adder stages, the one-bit-per-stage root,
// the divider setup and quotient stages, and the output register.
// Throughput is one request per cycle; busy stays low and the receiver cannot stall.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The unit keeps no state between requests.
module vec4_dot_norm_unit_top import vdn_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] a_w,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  input  logic signed [COMP_WIDTH-1:0] b_w,
  output logic                         valid,
  output logic signed [SCALAR_W-1:0]   scalar,
  output logic signed [NORM_W-1:0]     n_x,
  output logic signed [NORM_W-1:0]     n_y,
  output logic signed [NORM_W-1:0]     n_z,
  output logic signed [NORM_W-1:0]     n_w,
  output logic                         zero_magnitude
);

  localparam int SQ_FULL = 2 * COMP_WIDTH + 2;
  localparam int SQ_W    = (SQ_FULL > 64) ? 64 : SQ_FULL;
  localparam int MAG_W   = (SQ_W + 1) / 2;

  logic signed [3:0][COMP_WIDTH-1:0] in_a;
  logic signed [3:0][COMP_WIDTH-1:0] in_b;
  ctl_t                              mac_ctl;
  logic        [SQ_W-1:0]            mac_sq;
  logic signed [3:0][COMP_WIDTH-1:0] mac_a;
  ctl_t                              rt_ctl;
  logic        [MAG_W-1:0]           rt_mag;
  logic signed [3:0][COMP_WIDTH-1:0] rt_a;
  ctl_t                              ctl_sel;
  ctl_t                              dl_ctl [0:DIV_LAT];
  logic                              dl_nz  [0:DIV_LAT];
  logic        [3:0]                 d_neg;
  logic        [3:0]                 d_sat;
  logic        [3:0][QUOT_W-1:0]     d_quot;
  logic signed [3:0][NORM_W-1:0]     n_next;
  logic        [NORM_W-1:0]          qc;

  // The unit takes a request every cycle.
  assign busy = 1'b0;

  assign in_a = {a_w, a_z, a_y, a_x};
  assign in_b = {b_w, b_z, b_y, b_x};

  vdn_mac #(.COMP_WIDTH(COMP_WIDTH), .SQ_W(SQ_W)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .in_func  (func_t'(func)),
    .in_a     (in_a),
    .in_b     (in_b),
    .ctl      (mac_ctl),
    .sq       (mac_sq),
    .a_out    (mac_a)
  );

  vdn_sqrt #(.COMP_WIDTH(COMP_WIDTH), .SQ_W(SQ_W), .MAG_W(MAG_W)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (mac_ctl),
    .sq      (mac_sq),
    .a_in    (mac_a),
    .ctl_out (rt_ctl),
    .mag     (rt_mag),
    .a_out   (rt_a)
  );

  // Magnitude and normalize report the root as the scalar.
  always_comb begin
    ctl_sel = rt_ctl;
    if (rt_ctl.func == FUNC_MAG || rt_ctl.func == FUNC_NORM) begin
      ctl_sel.scalar = SCALAR_W'(rt_mag);
    end
  end

  // Four divider lanes.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    vdn_div #(.COMP_WIDTH(COMP_WIDTH), .MAG_W(MAG_W)) u_div (
      .clk  (clk),
      .a    (rt_a[i]),
      .mag  (rt_mag),
      .neg  (d_neg[i]),
      .sat  (d_sat[i]),
      .quot (d_quot[i])
    );
  end

  // Control delay line matching the divider latency.
  assign dl_ctl[0] = ctl_sel;
  assign dl_nz[0]  = (rt_mag != '0);
  for (genvar s = 0; s < DIV_LAT; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) begin
        dl_ctl[s+1].valid <= 1'b0;
      end else begin
        dl_ctl[s+1].valid <= dl_ctl[s].valid;
      end
      dl_ctl[s+1].func   <= dl_ctl[s].func;
      dl_ctl[s+1].zero   <= dl_ctl[s].zero;
      dl_ctl[s+1].scalar <= dl_ctl[s].scalar;
      dl_nz[s+1]         <= dl_nz[s];
    end
  end

  // Clamp to one, restore the sign, and zero the lanes outside normalize or at zero magnitude.
  always_comb begin
    qc = '0;
    for (int i = 0; i < 4; i++) begin
      if (d_sat[i] || (NORM_W'(d_quot[i]) > NORM_W'(NORM_ONE))) begin
        qc = NORM_W'(NORM_ONE);
      end else begin
        qc = NORM_W'(d_quot[i]);
      end
      if (dl_ctl[DIV_LAT].func == FUNC_NORM && dl_nz[DIV_LAT]) begin
        n_next[i] = d_neg[i] ? NORM_W'(-qc) : qc;
      end else begin
        n_next[i] = '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= dl_ctl[DIV_LAT].valid;
    end
    scalar         <= dl_ctl[DIV_LAT].scalar;
    zero_magnitude <= dl_ctl[DIV_LAT].zero;
    n_x            <= n_next[0];
    n_y            <= n_next[1];
    n_z            <= n_next[2];
    n_w            <= n_next[3];
  end

endmodule

/* verif/vdn_checker.sv */
// Checker that predicts and compares every result of the vector dot and normalize unit.
`timescale 1ns / 100ps
module vdn_checker import vdn_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 func,
  input  logic signed [15:0]         a_x,
  input  logic signed [15:0]         a_y,
  input  logic signed [15:0]         a_z,
  input  logic signed [15:0]         a_w,
  input  logic signed [15:0]         b_x,
  input  logic signed [15:0]         b_y,
  input  logic signed [15:0]         b_z,
  input  logic signed [15:0]         b_w,
  input  logic                       valid,
  input  logic signed [SCALAR_W-1:0] scalar,
  input  logic signed [NORM_W-1:0]   n_x,
  input  logic signed [NORM_W-1:0]   n_y,
  input  logic signed [NORM_W-1:0]   n_z,
  input  logic signed [NORM_W-1:0]   n_w,
  input  logic                       zero_magnitude,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [SCALAR_W-1:0] scalar;
    logic [NORM_W-1:0]   nx, ny, nz, nw;
    logic                zero;
  } vec_result_t;

  vec_result_t expected_results[$];
  int got_count;

  // Floor square root by the digit-by-digit method.
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // One component scaled into Q1.14, truncated and clamped to plus or minus one.
  function automatic logic [NORM_W-1:0] unit_comp(longint comp, longint unsigned mag);
    longint unsigned mag_abs, quot;
    longint signed_q;
    mag_abs = (comp < 0) ? -comp : comp;
    quot = (mag_abs << NORM_FRAC) / mag;
    if (quot > NORM_ONE) quot = NORM_ONE;
    signed_q = (comp < 0) ? -longint'(quot) : longint'(quot);
    return signed_q[NORM_W-1:0];
  endfunction

  function automatic vec_result_t predict_vec(func_t op, longint av[4], longint bv[4]);
    vec_result_t r;
    longint unsigned dot, sq, mag;
    dot = 0;
    sq = 0;
    for (int i = 0; i < 4; i++) begin
      dot += av[i] * bv[i];
      sq += av[i] * av[i];
    end
    mag = floor_sqrt(sq);
    r = '0;
    r.zero = (av[0] == 0 && av[1] == 0 && av[2] == 0 && av[3] == 0);
    case (op)
      FUNC_DOT: r.scalar = dot[SCALAR_W-1:0];
      FUNC_SQ:  r.scalar = sq[SCALAR_W-1:0];
      default:  r.scalar = mag[SCALAR_W-1:0];
    endcase
    if (op == FUNC_NORM && mag != 0) begin
      r.nx = unit_comp(av[0], mag);
      r.ny = unit_comp(av[1], mag);
      r.nz = unit_comp(av[2], mag);
      r.nw = unit_comp(av[3], mag);
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  // Predict on each accepted request and compare each result with the oldest prediction.
  always @(posedge clk) begin
    vec_result_t want, got;
    longint av[4], bv[4];
    if (rst) begin
      fail_count <= 0;
      got_count = 0;
    end else begin
      if (start && !busy) begin
        av = '{a_x, a_y, a_z, a_w};
        bv = '{b_x, b_y, b_z, b_w};
        expected_results.push_back(predict_vec(func_t'(func), av, bv));
      end
      if (valid) begin
        got = '{scalar, n_x, n_y, n_z, n_w, zero_magnitude};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result scalar=%h", $time, scalar);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          got_count++;
          if (got !== want) begin
            $display("%0t: mismatch exp scalar=%h n=%h %h %h %h z=%b",
                     $time, want.scalar, want.nx, want.ny, want.nz, want.nw, want.zero);
            $display("%0t:          act scalar=%h n=%h %h %h %h z=%b",
                     $time, got.scalar, got.nx, got.ny, got.nz, got.nw, got.zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/tb.sv */
// Testbench top: drives requests into the vector unit and reports the verdict.
`timescale 1ns / 100ps
module tb import vdn_pkg::*;;

  localparam int LAT = 36;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst, start, busy, valid, zero_magnitude;
  logic [1:0] func;
  logic signed [15:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
  logic signed [SCALAR_W-1:0] scalar;
  logic signed [NORM_W-1:0] n_x, n_y, n_z, n_w;
  int fail_count, pending, cycles, sent;

  vec4_dot_norm_unit_top uut (.*);
  vdn_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle limit guards against a hung unit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Component with a bias toward zero and the extremes.
  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one request and hold it until accepted.
  task automatic send_req(func_t op, logic [15:0] c[8]);
    start <= 1;
    func <= op;
    {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} <= {c[0], c[1], c[2], c[3],
                                                 c[4], c[5], c[6], c[7]};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  initial begin
    logic [15:0] c[8];
    cycles = 0;
    sent = 0;
    rst <= 1;
    start <= 0;
    func <= FUNC_DOT;
    {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} <= '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed requests: every operation on zero, extreme and unit-like vectors.
    for (int op = 0; op < 4; op++) begin
      c = '{default: 16'h0000};
      send_req(func_t'(op), c);
      c = '{default: 16'sh8000};
      send_req(func_t'(op), c);
      c = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'hffff};
      send_req(func_t'(op), c);
      c = '{16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'h0000, 16'h0000};
      send_req(func_t'(op), c);
      c = '{16'hffff, 16'h0001, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
      send_req(func_t'(op), c);
    end
    start <= 0;

    // Hold off until every prediction has been matched.
    while (pending != 0) @(posedge clk);

    // Random requests with random gaps; a stretch in the middle runs back to back.
    for (int i = 0; i < 900; i++) begin
      if ((i < 300 || i > 500) && $urandom_range(0, 99) < 19) begin
        start <= 0;
        @(posedge clk);
      end
      foreach (c[k]) c[k] = pick_comp();
      send_req(func_t'($urandom_range(0, 3)), c);
    end
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    $display("Sent %0d requests over all four operations, including zero and extreme vectors.",
             sent);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
